/* rtl/core/ism_pkg.sv */
// Package for the Ising Metropolis spin-update block: lattice geometry,
// widths, register indexes, sequencer types and the control struct.
// No dependencies.
package ism_pkg;

  // Lattice geometry (SIDE is a power of two; coordinates wrap by masking)
  localparam int unsigned SIDE    = 128;
  localparam int unsigned IDX_W   = $clog2(SIDE);
  localparam int unsigned NSITES  = SIDE * SIDE;
  localparam int unsigned ADDR_W  = 2 * IDX_W;

  // Fixed field widths
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned RND_W     = 16;
  localparam int unsigned MAG_OUT_W = 16;
  localparam int unsigned ENG_OUT_W = 17;
  localparam int unsigned SUM_W     = 4;   // neighbor sum, -4..+4

  // Internal totals: exact for the lattice, never narrower than the ports
  localparam int unsigned MAG_NEED = $clog2(NSITES) + 2;
  localparam int unsigned ENG_NEED = $clog2(NSITES) + 3;
  localparam int unsigned MAG_W    = (MAG_NEED > MAG_OUT_W) ? MAG_NEED : MAG_OUT_W;
  localparam int unsigned ENG_W    = (ENG_NEED > ENG_OUT_W) ? ENG_NEED : ENG_OUT_W;

  localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(longint'(NSITES));
  localparam logic signed [ENG_W-1:0] ENG_RESET = ENG_W'(-2 * longint'(NSITES));

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_RISE4 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_RISE8 = 1'b1;

  // Item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ATTEMPT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } ism_state_e;

  // Read order: site first, then the four neighbors
  typedef enum logic [2:0] {
    STEP_SITE,
    STEP_UP,
    STEP_DN,
    STEP_LF,
    STEP_RT
  } ism_step_e;

  typedef struct packed {
    logic              load;      // item beat accepted this cycle
    logic              rd;        // read phase
    logic              wr;        // decide / write-back cycle
    logic              clear;     // reset sweep of the lattice
    ism_step_e         step;      // address issued this read cycle
    logic [ADDR_W-1:0] clr_addr;
  } ism_ctrl_t;

endpackage

/* rtl/core/ism_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ism_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ism_ctrl.sv */
// Sequencer of the spin-update block: reset sweep, five lattice reads,
// write-back cycle. Depends on ism_pkg.
module ism_ctrl
  import ism_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ism_ctrl_t ctrl_o
);

  ism_state_e        state_q, state_d;
  ism_step_e         step_q, step_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              load;

  assign busy = (state_q == ST_CLEAR) || (state_q == ST_READ);
  assign load = start && !busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(NSITES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (load) state_d = ST_READ;
      ST_READ:  if (step_q == STEP_RT) state_d = ST_WRITE;
      ST_WRITE: state_d = load ? ST_READ : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Step and sweep counters
  always_comb begin
    step_d = step_q;
    clr_d  = clr_q;
    if (load) begin
      step_d = STEP_SITE;
    end else if (state_q == ST_READ) begin
      case (step_q)
        STEP_SITE: step_d = STEP_UP;
        STEP_UP:   step_d = STEP_DN;
        STEP_DN:   step_d = STEP_LF;
        STEP_LF:   step_d = STEP_RT;
        default:   step_d = STEP_SITE;
      endcase
    end
    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + ADDR_W'(1);
    end
  end

  // Outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.load     = load;
    ctrl_o.rd       = (state_q == ST_READ);
    ctrl_o.wr       = (state_q == ST_WRITE);
    ctrl_o.clear    = (state_q == ST_CLEAR);
    ctrl_o.step     = step_q;
    ctrl_o.clr_addr = clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= STEP_SITE;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
    end
  end

endmodule

/* rtl/core/ism_datapath.sv */
// Datapath of the spin-update block: item latch, lattice addressing,
// neighbor accumulator, acceptance compare and running totals. Depends on ism_pkg.
module ism_datapath
  import ism_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ism_ctrl_t                   ctrl_i,
  input  logic                        mode_i,
  input  logic [COORD_W-1:0]          row_i,
  input  logic [COORD_W-1:0]          col_i,
  input  logic                        spin_in_i,
  input  logic [RND_W-1:0]            random_value_i,
  input  logic [PROB_W-1:0]           prob4_i,
  input  logic [PROB_W-1:0]           prob8_i,
  output logic                        ram_we_o,
  output logic [ADDR_W-1:0]           ram_waddr_o,
  output logic                        ram_wdata_o,
  output logic                        ram_re_o,
  output logic [ADDR_W-1:0]           ram_raddr_o,
  input  logic                        ram_rdata_i,
  output logic                        done_o,
  output logic                        flipped_o,
  output logic                        spin_out_o,
  output logic signed [MAG_OUT_W-1:0] magnetization_o,
  output logic signed [ENG_OUT_W-1:0] energy_o
);

  logic [COORD_W+IDX_W-1:0] row_ext, col_ext;
  logic [IDX_W-1:0]         row_q, col_q;
  logic                     mode_q, spin_in_q;
  logic [RND_W-1:0]         rnd_q;
  logic                     site_q;
  logic signed [SUM_W-1:0]  acc_q, nb_step, acc_next, prod;
  logic signed [SUM_W:0]    rise2;
  logic [PROB_W-1:0]        prob_sel;
  logic                     rnd_below, flip;
  logic signed [MAG_W-1:0]  magnet_q;
  logic signed [ENG_W-1:0]  energy_q;
  logic                     done_q, flipped_q, spin_out_q;

  // Coordinates wrap modulo SIDE (power of two)
  assign row_ext = {{IDX_W{1'b0}}, row_i};
  assign col_ext = {{IDX_W{1'b0}}, col_i};

  // Item latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q    <= mode_i;
      row_q     <= row_ext[IDX_W-1:0];
      col_q     <= col_ext[IDX_W-1:0];
      spin_in_q <= spin_in_i;
      rnd_q     <= random_value_i;
    end
  end

  // Read address: site, then periodic neighbors
  always_comb begin
    case (ctrl_i.step)
      STEP_SITE: ram_raddr_o = {row_q, col_q};
      STEP_UP:   ram_raddr_o = {row_q - IDX_W'(1), col_q};
      STEP_DN:   ram_raddr_o = {row_q + IDX_W'(1), col_q};
      STEP_LF:   ram_raddr_o = {row_q, col_q - IDX_W'(1)};
      STEP_RT:   ram_raddr_o = {row_q, col_q + IDX_W'(1)};
      default:   ram_raddr_o = {row_q, col_q};
    endcase
  end
  assign ram_re_o = ctrl_i.rd;

  // Shared accumulator: read data arrives in the cycle after its address
  assign nb_step  = ram_rdata_i ? SUM_W'(1) : -SUM_W'(1);
  assign acc_next = acc_q + nb_step;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      case (ctrl_i.step)
        STEP_UP: begin
          site_q <= ram_rdata_i;
          acc_q  <= '0;
        end
        STEP_DN, STEP_LF, STEP_RT: acc_q <= acc_next;
        default: acc_q <= acc_q;
      endcase
    end
  end

  // Decision in the write cycle: acc_next holds the full neighbor sum
  assign prod      = site_q ? acc_next : -acc_next;
  assign prob_sel  = (prod == SUM_W'(2)) ? prob4_i : prob8_i;
  assign rnd_below = rnd_q < prob_sel;
  assign rise2     = {prod, 1'b0};

  always_comb begin
    if (mode_q == MODE_LOAD) begin
      flip = (spin_in_q != site_q);
    end else begin
      flip = prod[SUM_W-1] || (prod == '0) || rnd_below;
    end
  end

  // Lattice writes: reset sweep to +1, or the flipped site
  assign ram_we_o    = ctrl_i.clear || (ctrl_i.wr && flip);
  assign ram_waddr_o = ctrl_i.clear ? ctrl_i.clr_addr : {row_q, col_q};
  assign ram_wdata_o = ctrl_i.clear ? 1'b1 : !site_q;

  // Running totals; energy rises by 2*s*S on a flip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnet_q <= MAG_RESET;
      energy_q <= ENG_RESET;
      done_q   <= 1'b0;
    end else begin
      done_q <= ctrl_i.wr;
      if (ctrl_i.wr && flip) begin
        magnet_q <= site_q ? magnet_q - MAG_W'(2) : magnet_q + MAG_W'(2);
        energy_q <= energy_q + {{(ENG_W-SUM_W-1){rise2[SUM_W]}}, rise2};
      end
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      flipped_q  <= flip;
      spin_out_q <= flip ? !site_q : site_q;
    end
  end

  assign done_o          = done_q;
  assign flipped_o       = flipped_q;
  assign spin_out_o      = spin_out_q;
  assign magnetization_o = magnet_q[MAG_OUT_W-1:0];
  assign energy_o        = energy_q[ENG_OUT_W-1:0];

endmodule

/* rtl/core/ising_metropolis_spin_update.sv */
// Top level of the Ising Metropolis single-spin-flip block: config registers,
// sequencer, datapath and lattice RAM. Depends on ism_pkg, ism_ctrl, ism_datapath, ism_ram.
//
//  channel   handshake          payload
//  item in   start / busy       mode_i row_i col_i spin_in_i random_value_i
//  result    done_o (strobe)    flipped_o spin_out_o magnetization_o energy_o
//  config    cfg_we_i           cfg_idx_i cfg_data_i
//
// An item takes five reads (site and four neighbors) through the
// single lattice read port, then a decide/write-back cycle. The next item
// is taken in that write-back cycle, so a new item is accepted before the last one is through.
// The result beat shows on the cycle after write-back, for one cycle only;
// the receiver cannot stall it.
// After reset the lattice is swept to all +1, one site a cycle, with busy
// high for the whole sweep. Config writes are taken at any time.
module ising_metropolis_spin_update
  import ism_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [COORD_W-1:0]          row_i,
  input  logic [COORD_W-1:0]          col_i,
  input  logic                        spin_in_i,
  input  logic [RND_W-1:0]            random_value_i,
  output logic                        done_o,
  output logic                        flipped_o,
  output logic                        spin_out_o,
  output logic signed [MAG_OUT_W-1:0] magnetization_o,
  output logic signed [ENG_OUT_W-1:0] energy_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  ism_ctrl_t         ctrl;
  logic [PROB_W-1:0] prob4_q, prob8_q;
  logic              ram_we, ram_wdata, ram_re, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob4_q <= '0;
      prob8_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROB_RISE4: prob4_q <= cfg_data_i[PROB_W-1:0];
        CFG_PROB_RISE8: prob8_q <= cfg_data_i[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  ism_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  ism_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .mode_i          (mode_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .spin_in_i       (spin_in_i),
    .random_value_i  (random_value_i),
    .prob4_i         (prob4_q),
    .prob8_i         (prob8_q),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .done_o          (done_o),
    .flipped_o       (flipped_o),
    .spin_out_o      (spin_out_o),
    .magnetization_o (magnetization_o),
    .energy_o        (energy_o)
  );

  ism_ram #(
    .WIDTH (1),
    .DEPTH (NSITES)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A result beat only follows a write-back cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(ctrl.wr))
    else $error("result beat without write-back");

  // An accepted item keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // Magnetization moves exactly when a flip is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !flipped_o) |-> $stable(magnetization_o))
    else $error("magnetization changed without a flip");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flipped_o) |-> (magnetization_o != $past(magnetization_o)))
    else $error("flip reported but magnetization unchanged");

  // The lattice is never written while it is being read for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rd |-> !ram_we)
    else $error("lattice write during read phase");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for ising_metropolis_spin_update: loads and flip attempts
// against an in-bench lattice predictor. Depends on ism_pkg and the RTL top only.
`timescale 1ns / 1ps

module testbench;
  import ism_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 100000;  // several times the length of the clear sweep
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 256;

  typedef struct {
    logic                        flipped;
    logic                        spin;
    logic signed [MAG_OUT_W-1:0] magnet;
    logic signed [ENG_OUT_W-1:0] energy;
  } spin_result_t;

  // DUT ports, inputs all driven from time zero
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        start          = 1'b0;
  logic                        busy;
  logic                        mode_i         = MODE_LOAD;
  logic [COORD_W-1:0]          row_i          = '0;
  logic [COORD_W-1:0]          col_i          = '0;
  logic                        spin_in_i      = 1'b0;
  logic [RND_W-1:0]            random_value_i = '0;
  logic                        done_o;
  logic                        flipped_o;
  logic                        spin_out_o;
  logic signed [MAG_OUT_W-1:0] magnetization_o;
  logic signed [ENG_OUT_W-1:0] energy_o;
  logic                        cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i      = CFG_PROB_RISE4;
  logic [CFG_DATA_W-1:0]       cfg_data_i     = '0;

  // Lattice predictor state
  bit              lattice [NSITES];
  int              magnet_sum;
  int              energy_sum;
  bit [PROB_W-1:0] prob_rise4;
  bit [PROB_W-1:0] prob_rise8;
  spin_result_t    pending_results[$];
  spin_result_t    want;

  int errors     = 0;
  int n_loads    = 0;
  int n_attempts = 0;
  int n_flips    = 0;
  int n_checked  = 0;
  int gap_max    = 8;

  always #2 clk_i = ~clk_i;

  ising_metropolis_spin_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .spin_in_i      (spin_in_i),
    .random_value_i (random_value_i),
    .done_o         (done_o),
    .flipped_o      (flipped_o),
    .spin_out_o     (spin_out_o),
    .magnetization_o(magnetization_o),
    .energy_o       (energy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  function automatic int spin_at(int unsigned r, int unsigned c);
    return lattice[r * SIDE + c] ? 1 : -1;
  endfunction

  // Apply one item to the predicted lattice and totals; returns the expected beat
  function automatic spin_result_t update_site(logic mode, logic [COORD_W-1:0] row,
                                               logic [COORD_W-1:0] col, logic spin_bit,
                                               logic [RND_W-1:0] rnd);
    int unsigned  r;
    int unsigned  c;
    int           s;
    int           nsum;
    int           rise;
    bit           flip;
    spin_result_t res;
    r    = int'(row) % SIDE;
    c    = int'(col) % SIDE;
    s    = spin_at(r, c);
    nsum = spin_at((r + SIDE - 1) % SIDE, c) + spin_at((r + 1) % SIDE, c)
         + spin_at(r, (c + SIDE - 1) % SIDE) + spin_at(r, (c + 1) % SIDE);
    if (mode == MODE_LOAD) begin
      n_loads++;
      flip = ((spin_bit ? 1 : -1) != s);
    end else begin
      n_attempts++;
      rise = 2 * s * nsum;
      // downhill and flat moves always go; uphill ones race the threshold
      if (rise <= 0) flip = 1'b1;
      else if (rise == 4) flip = (rnd < prob_rise4);
      else flip = (rnd < prob_rise8);
    end
    if (flip) begin
      n_flips++;
      s = -s;
      lattice[r * SIDE + c] = (s > 0);
      magnet_sum += 2 * s;
      energy_sum -= 2 * s * nsum;
    end
    res.flipped = flip;
    res.spin    = lattice[r * SIDE + c];
    res.magnet  = MAG_OUT_W'(magnet_sum);
    res.energy  = ENG_OUT_W'(energy_sum);
    return res;
  endfunction

  // Send one item beat after a random gap; predicts it at the accepting edge
  task automatic send_item(logic mode, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic spin_bit, logic [RND_W-1:0] rnd);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= mode;
    row_i          <= row;
    col_i          <= col;
    spin_in_i      <= spin_bit;
    random_value_i <= rnd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.insert(pending_results.size(), update_site(mode, row, col, spin_bit, rnd));
  endtask

  // Stop sending and wait for every outstanding result beat
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Both thresholds, back to back; only called with the block idle
  task automatic write_probs(logic [PROB_W-1:0] p4, logic [PROB_W-1:0] p8);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PROB_RISE4;
    cfg_data_i <= p4;
    @(posedge clk_i);
    prob_rise4 = p4;
    cfg_idx_i  <= CFG_PROB_RISE8;
    cfg_data_i <= p8;
    @(posedge clk_i);
    prob_rise8 = p8;
    cfg_we_i   <= 1'b0;
  endtask

  // Thresholds at zero: uphill moves rejected, neighbor sums 4 down to -2 seen at one site
  task automatic test_zero_thresholds();
    write_probs('0, '0);
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'h0000);  // rise 8, rejected
    send_item(MODE_LOAD,    7'd64, 7'd64, 1'b1, 16'hFFFF);  // same spin, no change
    send_item(MODE_LOAD,    7'd64, 7'd64, 1'b0, 16'h1234);  // opposite spin
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b1, 16'hFFFF);  // drop 8, taken
    send_item(MODE_LOAD,    7'd64, 7'd65, 1'b0, 16'h0000);
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'h0000);  // rise 4, rejected
    send_item(MODE_LOAD,    7'd63, 7'd64, 1'b0, 16'h0000);
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'hFFFF);  // flat, taken
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b1, 16'hFFFF);  // flat, back again
    send_item(MODE_LOAD,    7'd65, 7'd64, 1'b0, 16'h0000);
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'h8000);  // drop 4, taken
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b1, 16'h0000);  // rise 4, rejected
    // corners: neighbor lookups wrap across both lattice edges
    send_item(MODE_LOAD,    7'd0,   7'd0,   1'b0, 16'h0000);
    send_item(MODE_LOAD,    7'd127, 7'd127, 1'b0, 16'h0000);
    send_item(MODE_LOAD,    7'd0,   7'd127, 1'b0, 16'h0000);
    send_item(MODE_LOAD,    7'd127, 7'd0,   1'b0, 16'h0000);
    send_item(MODE_ATTEMPT, 7'd0,   7'd0,   1'b1, 16'h7FFF);
    send_item(MODE_ATTEMPT, 7'd127, 7'd127, 1'b0, 16'h0001);
    drain();
  endtask

  // Thresholds at full scale: only the top random value rejects an uphill move
  task automatic test_full_thresholds();
    write_probs('1, '1);
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'hFFFE);  // rise 4, taken
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b0, 16'h0000);  // drop 4, taken
    send_item(MODE_ATTEMPT, 7'd64, 7'd64, 1'b1, 16'hFFFF);  // rise 4, rejected
    send_item(MODE_ATTEMPT, 7'd10, 7'd10, 1'b0, 16'hFFFF);  // rise 8, rejected
    send_item(MODE_ATTEMPT, 7'd10, 7'd10, 1'b1, 16'd100);   // rise 8, taken
    send_item(MODE_LOAD,    7'd10, 7'd10, 1'b1, 16'hFFFF);
    drain();
  endtask

  // Random items, mostly inside a small moving window so neighborhoods get mixed
  task automatic test_random_phase(logic [PROB_W-1:0] p4, logic [PROB_W-1:0] p8,
                                   bit wrap_window);
    logic [COORD_W-1:0] row_base;
    logic [COORD_W-1:0] col_base;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RND_W-1:0]   rnd;
    logic               mode;
    write_probs(p4, p8);
    row_base = '0;
    col_base = '0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 64 == 0) begin
        // every third stretch runs back to back
        gap_max  = ((i / 64) % 3 == 1) ? 0 : 8;
        row_base = wrap_window ? COORD_W'(125) : COORD_W'($urandom);
        col_base = wrap_window ? COORD_W'($urandom_range(124, 127)) : COORD_W'($urandom);
      end
      mode = ($urandom_range(0, 9) < 3) ? MODE_LOAD : MODE_ATTEMPT;
      if ($urandom_range(0, 3) == 0) begin
        row = COORD_W'($urandom);
        col = COORD_W'($urandom);
      end else begin
        row = row_base + COORD_W'($urandom_range(0, 5));
        col = col_base + COORD_W'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 9))
        0:       rnd = prob_rise4;
        1:       rnd = prob_rise8;
        2:       rnd = prob_rise4 - 1'b1;
        default: rnd = RND_W'($urandom);
      endcase
      send_item(mode, row, col, 1'($urandom), rnd);
    end
    gap_max = 8;
    drain();
  endtask

  // Result checker: one beat per done_o strobe, compared with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with no pending item", $realtime);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (flipped_o !== want.flipped || spin_out_o !== want.spin ||
            magnetization_o !== want.magnet || energy_o !== want.energy) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch exp/act flipped %0b/%0b spin %0b/%0b mag %0d/%0d eng %0d/%0d",
                     $realtime, want.flipped, flipped_o, want.spin, spin_out_o,
                     want.magnet, magnetization_o, want.energy, energy_o);
        end
      end
    end
  end

  // Watchdog: too long without an accepted item or a result beat
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (lattice[i]) lattice[i] = 1'b1;
    magnet_sum = NSITES;
    energy_sum = -2 * int'(NSITES);
    prob_rise4 = '0;
    prob_rise8 = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // let the lattice clear sweep finish before any config write
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    test_zero_thresholds();
    test_full_thresholds();
    test_random_phase(PROB_W'($urandom), PROB_W'($urandom), 1'b0);
    test_random_phase('1, '0, 1'b1);
    test_random_phase('0, '1, 1'b0);
    test_random_phase(16'h8000, 16'h2000, 1'b1);
    test_random_phase(PROB_W'($urandom), PROB_W'($urandom), 1'b1);

    errors += pending_results.size();
    $display("Covered %0d loads and %0d flip attempts (%0d spin changes), %0d beats checked",
             n_loads, n_attempts, n_flips, n_checked);
    $display("under zero, full-scale and random acceptance thresholds, with wrapped edges");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
